/* src/cre_pkg.sv */
// Package for the calendar rule date engine: rule kind codes and the
// Gregorian day arithmetic helpers used by the pipeline.
// Depends on nothing.
`default_nettype none
package cre_pkg;

    typedef enum logic [2:0] {
        ACT_FIXED    = 3'd0,
        ACT_NTH      = 3'd1,
        ACT_EASTER   = 3'd2,
        ACT_ON_AFTER = 3'd3,
        ACT_ROTATE   = 3'd4
    } t_action;

    localparam int unsigned LATENCY = 13;

    // Year offset of the internal day count: day 0 is March 1 of year -400.
    localparam logic [12:0] YEAR_BIAS = 13'd400;

    function automatic logic [2:0] mod7(input logic [21:0] x);
        logic [45:0] p;
        logic [19:0] q;
        logic [22:0] r;
        p = 46'(x) * 46'd9586981;
        q = p[45:26];
        r = 23'(x) - 23'(q) * 23'd7;
        mod7 = r[2:0];
    endfunction

    // Days from the epoch to March 1 of the biased year y.
    function automatic logic [21:0] days_of(input logic [12:0] y);
        logic [25:0] p;
        logic [6:0]  q100;
        p = 26'(y) * 26'd5243;
        q100 = p[25:19];
        days_of = 22'(y) * 22'd365 + 22'(y[12:2]) - 22'(q100) + 22'(q100[6:2]);
    endfunction

    // Day of the March-based year on which month index mp begins.
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        case (mp)
            4'd0: doy_of = 9'd0;
            4'd1: doy_of = 9'd31;
            4'd2: doy_of = 9'd61;
            4'd3: doy_of = 9'd92;
            4'd4: doy_of = 9'd122;
            4'd5: doy_of = 9'd153;
            4'd6: doy_of = 9'd184;
            4'd7: doy_of = 9'd214;
            4'd8: doy_of = 9'd245;
            4'd9: doy_of = 9'd275;
            4'd10: doy_of = 9'd306;
            4'd11: doy_of = 9'd337;
            default: doy_of = 9'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

/* src/calendar_rule_date_engine_top.sv */
// Pipelined calendar rule date engine: turns a year and one date rule into
// a Gregorian date, weekday and packed date word.
// Depends on cre_pkg.
//
// The block takes one word per clock cycle and never raises busy. Every
// result appears with o_valid in order, once it has passed through the
// pipeline (Easter computus, day count, weekday alignment, year search and
// month split), and the receiver cannot stall it.
`default_nettype none
module calendar_rule_date_engine_top
    import cre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_action,
    input  wire logic [11:0]        i_year,
    input  wire logic [3:0]         i_month,
    input  wire logic [4:0]         i_day_or_count,
    input  wire logic [2:0]         i_weekday,
    input  wire logic signed [5:0]  i_day_offset,
    output logic                    o_valid,
    output logic [11:0]             o_result_year,
    output logic [3:0]              o_result_month,
    output logic [4:0]              o_result_day,
    output logic [2:0]              o_result_weekday,
    output logic [28:0]             o_packed_date,
    output logic                    o_year_out_of_range
);

    assign busy = 1'b0;

    // Stage 1: input capture.
    logic              r1_vld;
    logic [2:0]        r1_action;
    logic [11:0]       r1_year;
    logic [3:0]        r1_month;
    logic [4:0]        r1_dc;
    logic [2:0]        r1_wd;
    logic signed [5:0] r1_off;

    // Stage 2: rule decode and first computus quotients.
    logic              r2_vld, r2_need, r2_zero, r2_east;
    logic [11:0]       r2_year;
    logic [7:0]        r2_q19;
    logic [5:0]        r2_b;
    logic signed [1:0] r2_adj;
    logic [3:0]        r2_mp;
    logic signed [5:0] r2_dd;
    logic signed [9:0] r2_ext;
    logic [2:0]        r2_wd;

    logic [3:0]        n2_mo;
    logic signed [1:0] n2_adj;
    logic [3:0]        n2_mp;
    logic signed [5:0] n2_dd;
    logic signed [9:0] n2_ext;
    logic signed [9:0] n2_dcm1;
    logic              n2_need, n2_zero;
    logic [2:0]        n2_wd;
    logic [23:0]       n2_p19;
    logic [24:0]       n2_p100;

    assign n2_p19  = 24'(r1_year) * 24'd3450;
    assign n2_p100 = 25'(r1_year) * 25'd5243;
    assign n2_dcm1 = $signed({5'b0, r1_dc}) - 10'sd1;

    always_comb begin
        n2_mo = (r1_action == ACT_ROTATE && r1_month == 4'd0) ? 4'd3 : r1_month;
        case (n2_mo)
            4'd0: begin
                n2_adj = -2'sd1;
                n2_mp  = 4'd9;
            end
            4'd1: begin
                n2_adj = -2'sd1;
                n2_mp  = 4'd10;
            end
            4'd2: begin
                n2_adj = -2'sd1;
                n2_mp  = 4'd11;
            end
            4'd13: begin
                n2_adj = 2'sd0;
                n2_mp  = 4'd10;
            end
            4'd14: begin
                n2_adj = 2'sd0;
                n2_mp  = 4'd11;
            end
            4'd15: begin
                n2_adj = 2'sd1;
                n2_mp  = 4'd0;
            end
            default: begin
                n2_adj = 2'sd0;
                n2_mp  = n2_mo - 4'd3;
            end
        endcase
        n2_dd   = 6'sd0;
        n2_ext  = 10'sd0;
        n2_need = 1'b0;
        n2_zero = 1'b0;
        n2_wd   = (r1_wd == 3'd7) ? 3'd0 : r1_wd;
        case (r1_action)
            ACT_FIXED: begin
                n2_dd = $signed({1'b0, r1_dc}) - 6'sd1;
            end
            ACT_NTH: begin
                n2_need = 1'b1;
                n2_ext  = n2_dcm1 * 10'sd7 + 10'(r1_off);
            end
            ACT_EASTER: begin
                n2_ext = 10'(r1_off);
            end
            ACT_ON_AFTER: begin
                n2_need = 1'b1;
                n2_dd   = $signed({1'b0, r1_dc}) - 6'sd1;
                n2_ext  = 10'(r1_off);
            end
            ACT_ROTATE: begin
                n2_need = 1'b1;
                n2_wd   = 3'd0;
                n2_zero = (r1_month > 4'd2);
            end
            default: begin
                n2_zero = 1'b1;
            end
        endcase
    end

    // Stage 3: remaining computus terms.
    logic              r3_vld, r3_need, r3_zero, r3_east;
    logic [11:0]       r3_year;
    logic signed [1:0] r3_adj;
    logic [3:0]        r3_mp;
    logic signed [5:0] r3_dd;
    logic signed [9:0] r3_ext;
    logic [2:0]        r3_wd;
    logic [4:0]        r3_a;
    logic [5:0]        r3_b;
    logic [3:0]        r3_d;
    logic [1:0]        r3_e;
    logic [3:0]        r3_g;
    logic [4:0]        r3_i;
    logic [1:0]        r3_k;

    logic [11:0] n3_a, n3_c;
    logic [5:0]  n3_x;
    logic [12:0] n3_pg;

    assign n3_a  = r2_year - 12'(r2_q19) * 12'd19;
    assign n3_c  = r2_year - 12'(r2_b) * 12'd100;
    assign n3_x  = r2_b - ((r2_b >= 6'd17) ? 6'd1 : 6'd0) + 6'd1;
    assign n3_pg = 13'(n3_x) * 13'd171;

    // Stage 4: epact.
    logic              r4_vld, r4_need, r4_zero, r4_east;
    logic [11:0]       r4_year;
    logic signed [1:0] r4_adj;
    logic [3:0]        r4_mp;
    logic signed [5:0] r4_dd;
    logic signed [9:0] r4_ext;
    logic [2:0]        r4_wd;
    logic [4:0]        r4_a, r4_h, r4_i;
    logic [1:0]        r4_e, r4_k;

    logic [9:0]  n4_x, n4_h;
    logic [19:0] n4_p;

    assign n4_x = 10'(r3_a) * 10'd19 + 10'(r3_b) - 10'(r3_d) - 10'(r3_g) + 10'd15;
    assign n4_p = 20'(n4_x) * 20'd2185;
    assign n4_h = n4_x - 10'(n4_p[19:16]) * 10'd30;

    // Stage 5: weekday correction of the computus.
    logic              r5_vld, r5_need, r5_zero, r5_east;
    logic [11:0]       r5_year;
    logic signed [1:0] r5_adj;
    logic [3:0]        r5_mp;
    logic signed [5:0] r5_dd;
    logic signed [9:0] r5_ext;
    logic [2:0]        r5_wd;
    logic [4:0]        r5_a, r5_h;
    logic [2:0]        r5_l;

    logic [6:0] n5_y;

    assign n5_y = 7'd32 + {4'b0, r4_e, 1'b0} + {1'b0, r4_i, 1'b0} - 7'(r4_h) - 7'(r4_k);

    // Stage 6: Easter date and base date selection.
    logic              r6_vld, r6_need, r6_zero;
    logic [12:0]       r6_y;
    logic [3:0]        r6_mp;
    logic signed [5:0] r6_dd;
    logic signed [9:0] r6_ext;
    logic [2:0]        r6_wd;

    logic [8:0] n6_t;
    logic [7:0] n6_s;

    assign n6_t = 9'(r5_a) + 9'(r5_h) * 9'd11 + 9'(r5_l) * 9'd22;
    assign n6_s = 8'(r5_h) + 8'(r5_l) + 8'd114 - ((n6_t >= 9'd451) ? 8'd7 : 8'd0);

    // Stage 7: day count of the base date.
    logic              r7_vld, r7_need, r7_zero;
    logic [21:0]       r7_z;
    logic signed [9:0] r7_ext;
    logic [2:0]        r7_wd;

    // Stage 8: weekday alignment and offset.
    logic        r8_vld, r8_zero;
    logic [21:0] r8_z;

    logic [2:0] n8_wk;
    logic [3:0] n8_t;
    logic [2:0] n8_adv;

    assign n8_wk  = mod7(r7_z + 22'd3);
    assign n8_t   = {1'b0, r7_wd} + 4'd7 - {1'b0, n8_wk};
    assign n8_adv = (n8_t >= 4'd7) ? 3'(n8_t - 4'd7) : n8_t[2:0];

    // Stage 9: year estimate and result weekday.
    logic        r9_vld, r9_zero;
    logic [21:0] r9_z;
    logic [12:0] r9_ye;
    logic [2:0]  r9_rw;

    logic [45:0] n9_p;

    assign n9_p = 46'(r8_z) * 46'd11759221;

    // Stage 10: year boundaries around the estimate.
    logic        r10_vld, r10_zero;
    logic [21:0] r10_z, r10_dm, r10_d0, r10_dp;
    logic [12:0] r10_ye;
    logic [2:0]  r10_rw;

    // Stage 11: year selection.
    logic        r11_vld, r11_zero;
    logic [12:0] r11_y;
    logic [8:0]  r11_doy;
    logic [2:0]  r11_rw;

    logic [12:0] n11_y;
    logic [21:0] n11_doy;

    always_comb begin
        if (r10_z < r10_d0) begin
            n11_y   = r10_ye - 13'd1;
            n11_doy = r10_z - r10_dm;
        end else if (r10_z >= r10_dp) begin
            n11_y   = r10_ye + 13'd1;
            n11_doy = r10_z - r10_dp;
        end else begin
            n11_y   = r10_ye;
            n11_doy = r10_z - r10_d0;
        end
    end

    // Stage 12: month split.
    logic        r12_vld, r12_zero;
    logic [12:0] r12_y;
    logic [8:0]  r12_doy;
    logic [3:0]  r12_mp;
    logic [2:0]  r12_rw;

    logic [20:0] n12_p;

    assign n12_p = 21'(11'(r11_doy) * 11'd5 + 11'd2) * 21'd857;

    // Stage 13: output assembly.
    logic signed [13:0] n13_ry;
    logic [8:0]         n13_day;
    logic [3:0]         n13_mon;
    logic [4:0]         n13_yoff;
    logic               n13_flag;

    always_comb begin
        n13_ry  = $signed({1'b0, r12_y}) - $signed({1'b0, YEAR_BIAS})
                  + ((r12_mp >= 4'd10) ? 14'sd1 : 14'sd0);
        n13_day = r12_doy - doy_of(r12_mp) + 9'd1;
        n13_mon = (r12_mp < 4'd10) ? r12_mp + 4'd3 : r12_mp - 4'd9;
        if (n13_ry < 14'sd2000) begin
            n13_yoff = 5'd0;
            n13_flag = 1'b0;
        end else if (n13_ry > 14'sd2031) begin
            n13_yoff = 5'd31;
            n13_flag = 1'b1;
        end else begin
            n13_yoff = 5'(n13_ry - 14'sd2000);
            n13_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r1_vld  <= start && !busy;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
            o_valid <= r12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_action <= i_action;
        r1_year   <= i_year;
        r1_month  <= i_month;
        r1_dc     <= i_day_or_count;
        r1_wd     <= i_weekday;
        r1_off    <= i_day_offset;

        r2_year <= r1_year;
        r2_q19  <= n2_p19[23:16];
        r2_b    <= n2_p100[24:19];
        r2_adj  <= n2_adj;
        r2_mp   <= n2_mp;
        r2_dd   <= n2_dd;
        r2_ext  <= n2_ext;
        r2_need <= n2_need;
        r2_zero <= n2_zero;
        r2_wd   <= n2_wd;
        r2_east <= (r1_action == ACT_EASTER);

        r3_year <= r2_year;
        r3_adj  <= r2_adj;
        r3_mp   <= r2_mp;
        r3_dd   <= r2_dd;
        r3_ext  <= r2_ext;
        r3_need <= r2_need;
        r3_zero <= r2_zero;
        r3_wd   <= r2_wd;
        r3_east <= r2_east;
        r3_a    <= n3_a[4:0];
        r3_b    <= r2_b;
        r3_d    <= r2_b[5:2];
        r3_e    <= r2_b[1:0];
        r3_g    <= n3_pg[12:9];
        r3_i    <= n3_c[6:2];
        r3_k    <= n3_c[1:0];

        r4_year <= r3_year;
        r4_adj  <= r3_adj;
        r4_mp   <= r3_mp;
        r4_dd   <= r3_dd;
        r4_ext  <= r3_ext;
        r4_need <= r3_need;
        r4_zero <= r3_zero;
        r4_wd   <= r3_wd;
        r4_east <= r3_east;
        r4_a    <= r3_a;
        r4_h    <= n4_h[4:0];
        r4_e    <= r3_e;
        r4_i    <= r3_i;
        r4_k    <= r3_k;

        r5_year <= r4_year;
        r5_adj  <= r4_adj;
        r5_mp   <= r4_mp;
        r5_dd   <= r4_dd;
        r5_ext  <= r4_ext;
        r5_need <= r4_need;
        r5_zero <= r4_zero;
        r5_wd   <= r4_wd;
        r5_east <= r4_east;
        r5_a    <= r4_a;
        r5_h    <= r4_h;
        r5_l    <= mod7(22'(n5_y));

        r6_need <= r5_need;
        r6_zero <= r5_zero;
        r6_ext  <= r5_ext;
        r6_wd   <= r5_wd;
        if (r5_east) begin
            r6_y <= 13'(r5_year) + YEAR_BIAS;
            if (n6_s >= 8'd124) begin
                r6_mp <= 4'd1;
                r6_dd <= 6'(n6_s - 8'd124);
            end else begin
                r6_mp <= 4'd0;
                r6_dd <= 6'(n6_s - 8'd93);
            end
        end else begin
            r6_y  <= 13'(r5_year) + 13'(r5_adj) + YEAR_BIAS;
            r6_mp <= r5_mp;
            r6_dd <= r5_dd;
        end

        r7_z    <= days_of(r6_y) + 22'(doy_of(r6_mp)) + 22'(r6_dd);
        r7_need <= r6_need;
        r7_zero <= r6_zero;
        r7_ext  <= r6_ext;
        r7_wd   <= r6_wd;

        r8_z    <= r7_z + (r7_need ? 22'(n8_adv) : 22'd0) + 22'(r7_ext);
        r8_zero <= r7_zero;

        r9_z    <= r8_z;
        r9_ye   <= n9_p[44:32];
        r9_rw   <= mod7(r8_z + 22'd3);
        r9_zero <= r8_zero;

        r10_z    <= r9_z;
        r10_ye   <= r9_ye;
        r10_dm   <= days_of(r9_ye - 13'd1);
        r10_d0   <= days_of(r9_ye);
        r10_dp   <= days_of(r9_ye + 13'd1);
        r10_rw   <= r9_rw;
        r10_zero <= r9_zero;

        r11_y    <= n11_y;
        r11_doy  <= n11_doy[8:0];
        r11_rw   <= r10_rw;
        r11_zero <= r10_zero;

        r12_y    <= r11_y;
        r12_doy  <= r11_doy;
        r12_mp   <= n12_p[20:17];
        r12_rw   <= r11_rw;
        r12_zero <= r11_zero;

        if (r12_zero) begin
            o_result_year       <= 12'd0;
            o_result_month      <= 4'd0;
            o_result_day        <= 5'd0;
            o_result_weekday    <= 3'd0;
            o_packed_date       <= 29'd0;
            o_year_out_of_range <= 1'b0;
        end else begin
            o_result_year       <= n13_ry[11:0];
            o_result_month      <= n13_mon;
            o_result_day        <= n13_day[4:0];
            o_result_weekday    <= r12_rw;
            o_packed_date       <= {n13_yoff, n13_mon - 4'd1, 1'b0, 5'(n13_day[4:0] - 5'd1),
                                    r12_rw, 11'd0};
            o_year_out_of_range <= n13_flag;
        end
    end

endmodule
`default_nettype wire

/* src/cre_checker.sv */
// Port-level checker for the calendar rule date engine and its bind.
// Depends on cre_pkg and calendar_rule_date_engine_top.
`default_nettype none
module cre_port_checker
    import cre_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [2:0]  o_result_weekday,
    input wire logic [28:0] o_packed_date
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy was raised");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without an accepted word");

    a_packed_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_packed_date[10:0] == 11'd0
                     && o_packed_date[13:11] == o_result_weekday
                     && o_result_weekday != 3'd7))
        else $error("packed word disagrees with weekday");

endmodule

bind calendar_rule_date_engine_top cre_port_checker u_cre_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_result_weekday (o_result_weekday),
    .o_packed_date    (o_packed_date)
);
`default_nettype wire

/* dv/cre_checker.sv */
// Checker for the calendar rule date engine: predicts each result from the accepted word
// and compares the returned words in order. Depends on cre_pkg for the rule kind codes.
`timescale 1ns / 1ps
module cre_checker
    import cre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [2:0]         i_action,
    input  wire logic [11:0]        i_year,
    input  wire logic [3:0]         i_month,
    input  wire logic [4:0]         i_day_or_count,
    input  wire logic [2:0]         i_weekday,
    input  wire logic signed [5:0]  i_day_offset,
    input  wire logic               o_valid,
    input  wire logic [11:0]        o_result_year,
    input  wire logic [3:0]         o_result_month,
    input  wire logic [4:0]         o_result_day,
    input  wire logic [2:0]         o_result_weekday,
    input  wire logic [28:0]        o_packed_date,
    input  wire logic               o_year_out_of_range,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [28:0] packed_word;
        logic        flag;
    } t_date_word;

    t_date_word dates_due[$];
    int         fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = dates_due.size();

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    function automatic longint floor_mod(input longint a, input longint b);
        return a - floor_div(a, b) * b;
    endfunction

    function automatic longint epoch_day(input longint y, input longint m, input longint d);
        longint yy, mm, era, yoe, mp, doy;
        yy = y + floor_div(m - 1, 12);
        mm = floor_mod(m - 1, 12) + 1;
        if (mm <= 2) yy -= 1;
        era = floor_div(yy, 400);
        yoe = yy - era * 400;
        mp = (mm + 9) % 12;
        doy = (153 * mp + 2) / 5;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468 + (d - 1);
    endfunction

    function automatic longint day_of_week(input longint z);
        return floor_mod(z + 4, 7);
    endfunction

    function automatic longint next_weekday(input longint z, input longint wd);
        return z + floor_mod(wd - day_of_week(z), 7);
    endfunction

    function automatic longint easter_sunday(input longint y);
        longint a, b, c, d, e, f, g, h, i, k, l, mm, s;
        a = y % 19; b = y / 100; c = y % 100;
        d = b / 4; e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        i = c / 4; k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        mm = (a + 11 * h + 22 * l) / 451;
        s = h + l - 7 * mm + 114;
        return epoch_day(y, s / 31, (s % 31) + 1);
    endfunction

    function automatic t_date_word predict_date(input logic [2:0] act, input logic [11:0] yr,
            input logic [3:0] mo, input logic [4:0] dc, input logic [2:0] wdi,
            input logic signed [5:0] ofs);
        t_date_word r;
        longint z, wd, off, era, doe, yoe, doy, mp, ry, rm, rd, rw, yoff;
        r = '0;
        wd = longint'(wdi) % 7;
        off = longint'(ofs);
        case (act)
            ACT_FIXED:    z = epoch_day(yr, mo, dc);
            ACT_NTH:      z = next_weekday(epoch_day(yr, mo, 1), wd) + (dc - 1) * 7 + off;
            ACT_EASTER:   z = easter_sunday(yr) + off;
            ACT_ON_AFTER: z = next_weekday(epoch_day(yr, mo, dc), wd) + off;
            ACT_ROTATE: begin
                if (mo > 2) return r;
                z = next_weekday(epoch_day(yr, (mo == 0) ? 3 : mo, 1), 0);
            end
            default: return r;
        endcase
        z += 719468;
        era = floor_div(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        rd = doy - (153 * mp + 2) / 5 + 1;
        rm = (mp < 10) ? mp + 3 : mp - 9;
        ry = yoe + era * 400 + ((rm <= 2) ? 1 : 0);
        rw = day_of_week(z - 719468);
        yoff = (ry < 2000) ? 0 : (ry > 2031) ? 31 : ry - 2000;
        r.year = ry[11:0];
        r.month = rm[3:0];
        r.day = rd[4:0];
        r.wday = rw[2:0];
        r.flag = ry > 2031;
        r.packed_word = {yoff[4:0], 4'(rm - 1), 6'(rd - 1), rw[2:0], 11'd0};
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_date_word want;
        if (i_rst_n && start && !busy)
            dates_due = {dates_due, predict_date(i_action, i_year, i_month, i_day_or_count,
                                                 i_weekday, i_day_offset)};
        if (i_rst_n && o_valid) begin
            if (dates_due.size() == 0) begin
                report_mismatch("pending words", 0, 1);
            end else begin
                want = dates_due.pop_front();
                if (o_result_year != want.year)
                    report_mismatch("year", o_result_year, want.year);
                if (o_result_month != want.month)
                    report_mismatch("month", o_result_month, want.month);
                if (o_result_day != want.day)
                    report_mismatch("day", o_result_day, want.day);
                if (o_result_weekday != want.wday)
                    report_mismatch("weekday", o_result_weekday, want.wday);
                if (o_packed_date != want.packed_word)
                    report_mismatch("packed_date", o_packed_date, want.packed_word);
                if (o_year_out_of_range != want.flag)
                    report_mismatch("year_out_of_range", o_year_out_of_range, want.flag);
            end
        end
    end

endmodule

/* dv/tb_calendar_rule_date_engine_top.sv */
// Testbench top for the calendar rule date engine: drives directed and random rule words
// and gives the verdict. Depends on cre_pkg, calendar_rule_date_engine_top and cre_checker.
`timescale 1ns / 1ps
module tb_calendar_rule_date_engine_top;
    import cre_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_action = '0;
    logic [11:0]        i_year = '0;
    logic [3:0]         i_month = '0;
    logic [4:0]         i_day_or_count = '0;
    logic [2:0]         i_weekday = '0;
    logic signed [5:0]  i_day_offset = '0;
    logic               o_valid;
    logic [11:0]        o_result_year;
    logic [3:0]         o_result_month;
    logic [4:0]         o_result_day;
    logic [2:0]         o_result_weekday;
    logic [28:0]        o_packed_date;
    logic               o_year_out_of_range;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;

    always #4 i_clk = ~i_clk;

    calendar_rule_date_engine_top dut (.*);

    cre_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_rule(input logic [2:0] act, input logic [11:0] yr, input logic [3:0] mo,
            input logic [4:0] dc, input logic [2:0] wd, input logic [5:0] ofs);
        start <= 1'b1;
        i_action <= act;
        i_year <= yr;
        i_month <= mo;
        i_day_or_count <= dc;
        i_weekday <= wd;
        i_day_offset <= ofs;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    task automatic send_random(input int idx);
        logic [2:0]  act;
        logic [11:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dc;
        if ($urandom_range(99) < 15) begin
            send_rule(3'($urandom), 12'($urandom), 4'($urandom), 5'($urandom), 3'($urandom),
                      6'($urandom));
        end else begin
            act = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            yr = 12'($urandom_range(2099, 2000));
            mo = (act == ACT_ROTATE) ? 4'($urandom_range(2)) : 4'($urandom_range(12, 1));
            dc = (act == ACT_NTH) ? 5'($urandom_range(5, 1)) : 5'($urandom_range(28, 1));
            send_rule(act, yr, mo, dc, 3'($urandom_range(6)), 6'($urandom));
        end
        if ((idx < 600 || idx > 950) && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_rule(ACT_FIXED, 12'd2000, 4'd2, 5'd29, 3'd0, 6'd0);
        send_rule(ACT_FIXED, 12'd2000, 4'd1, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_FIXED, 12'd2000, 4'd0, 5'd1, 3'd0, 6'd0);
        send_rule(ACT_FIXED, 12'd2099, 4'd13, 5'd31, 3'd0, 6'd0);
        send_rule(ACT_FIXED, 12'd2031, 4'd15, 5'd31, 3'd7, 6'h1f);
        send_rule(ACT_FIXED, 12'd0, 4'd0, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_FIXED, 12'd4095, 4'd15, 5'd31, 3'd7, 6'h3f);
        send_rule(ACT_NTH, 12'd2024, 4'd5, 5'd0, 3'd1, 6'd0);
        send_rule(ACT_NTH, 12'd2024, 4'd3, 5'd5, 3'd7, 6'h20);
        send_rule(ACT_NTH, 12'd2031, 4'd12, 5'd31, 3'd6, 6'h1f);
        send_rule(ACT_EASTER, 12'd2000, 4'd0, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_EASTER, 12'd2099, 4'd15, 5'd31, 3'd7, 6'h20);
        send_rule(ACT_EASTER, 12'd2032, 4'd0, 5'd0, 3'd0, 6'h1f);
        send_rule(ACT_EASTER, 12'd4095, 4'd0, 5'd0, 3'd0, 6'h1f);
        send_rule(ACT_ON_AFTER, 12'd2000, 4'd1, 5'd1, 3'd7, 6'h20);
        send_rule(ACT_ON_AFTER, 12'd2099, 4'd12, 5'd31, 3'd3, 6'h1f);
        send_rule(ACT_ROTATE, 12'd2025, 4'd0, 5'd9, 3'd3, 6'h11);
        send_rule(ACT_ROTATE, 12'd2025, 4'd1, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_ROTATE, 12'd2099, 4'd2, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_ROTATE, 12'd2025, 4'd3, 5'd0, 3'd0, 6'd0);
        send_rule(ACT_ROTATE, 12'd2025, 4'd15, 5'd0, 3'd0, 6'd0);
        send_rule(3'd5, 12'd2025, 4'd1, 5'd1, 3'd0, 6'd0);
        send_rule(3'd6, 12'd2025, 4'd1, 5'd1, 3'd0, 6'd0);
        send_rule(3'd7, 12'd4095, 4'd15, 5'd31, 3'd7, 6'h3f);
        for (int n = 0; n < 1430; n++) begin
            send_random(n);
            if (n == 300) begin
                start <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
